/* sv/spg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse generator package
// Field widths, command and register codes, divider constants and the
// command and status types shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package spg_pkg;

    localparam int CMD_W      = 2;
    localparam int MOTOR_W    = 3;
    localparam int RPM_W      = 8;
    localparam int TIME_W     = 32;
    localparam int SPR_W      = 16;
    localparam int HP_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_SET_SPEED = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STOP      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP_ALL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SPR_SPECIAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPR_DEFAULT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT      = 2'd2;

    localparam logic [SPR_W-1:0]   SPR_SPECIAL_RST = 16'd3200;
    localparam logic [SPR_W-1:0]   SPR_DEFAULT_RST = 16'd1600;
    localparam logic [MOTOR_W-1:0] SPECIAL_MOTOR   = 3'd3;
    localparam logic [MOTOR_W-1:0] PAIR_MOTOR_A    = 3'd1;
    localparam logic [MOTOR_W-1:0] PAIR_MOTOR_B    = 3'd2;

    localparam int DIVIDEND_W = 26;
    localparam int DIVISOR_W  = SPR_W + RPM_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam logic [DIVIDEND_W-1:0] US_PER_MINUTE = 26'd60000000;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div_step;
        logic commit;
    } spg_ctrl_t;

    typedef struct packed {
        logic needs_div;
    } spg_status_t;

endpackage

/* sv/spg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse generator channels
// Command channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface spg_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [spg_pkg::CMD_W-1:0]    command;
    logic [spg_pkg::MOTOR_W-1:0]  motor_id;
    logic [spg_pkg::RPM_W-1:0]    rpm;
    logic                         direction;
    logic [spg_pkg::TIME_W-1:0]   time_us;

    modport source (output valid, command, motor_id, rpm, direction, time_us, input ready);
    modport sink (input valid, command, motor_id, rpm, direction, time_us, output ready);
endinterface

interface spg_res_if #(parameter int NUM_MOTORS = 5);
    logic                  valid;
    logic                  ready;
    logic [NUM_MOTORS-1:0] step_levels;
    logic [NUM_MOTORS-1:0] dir_levels;
    logic [NUM_MOTORS-1:0] running_mask;
    logic                  conflict_stop;

    modport source (output valid, step_levels, dir_levels, running_mask, conflict_stop,
                    input ready);
    modport sink (input valid, step_levels, dir_levels, running_mask, conflict_stop,
                  output ready);
endinterface

interface spg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [spg_pkg::CFG_IDX_W-1:0]   index;
    logic [spg_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* sv/spg_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse generator controller
// Sequences capture, multiply, divide and commit, and owns both handshakes.
// ----------------------------------------------------------------------------
module spg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  spg_pkg::spg_status_t status,
    output spg_pkg::spg_ctrl_t   ctrl
);
    import spg_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MUL    = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 accept;
    logic                 can_commit;

    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign can_commit = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl           = '0;
        ctrl.capture   = accept;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                ctrl.mul = 1'b1;
                cnt_next = '0;
                state_next = status.needs_div ? ST_DIV : ST_COMMIT;
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (can_commit)
                begin
                    ctrl.commit    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sv/spg_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse generator datapath
// Configuration registers, captured command, multiplier, restoring divider,
// per-channel motor state and the result register.
// ----------------------------------------------------------------------------
module spg_datapath #(
    parameter int NUM_MOTORS = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  spg_pkg::spg_ctrl_t               ctrl,
    output spg_pkg::spg_status_t             status,
    input  logic [spg_pkg::CMD_W-1:0]        command,
    input  logic [spg_pkg::MOTOR_W-1:0]      motor_id,
    input  logic [spg_pkg::RPM_W-1:0]        rpm,
    input  logic                             direction,
    input  logic [spg_pkg::TIME_W-1:0]       time_us,
    input  logic                             cfg_write,
    input  logic [spg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spg_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [NUM_MOTORS-1:0]            step_levels,
    output logic [NUM_MOTORS-1:0]            dir_levels,
    output logic [NUM_MOTORS-1:0]            running_mask,
    output logic                             conflict_stop
);
    import spg_pkg::*;

    localparam int ID_W = MOTOR_W + 1;

    logic [SPR_W-1:0]      spr_special_reg;
    logic [SPR_W-1:0]      spr_default_reg;
    logic [NUM_MOTORS-1:0] invert_reg;

    logic [CMD_W-1:0]   cap_cmd_reg;
    logic [MOTOR_W-1:0] cap_motor_reg;
    logic [RPM_W-1:0]   cap_rpm_reg;
    logic               cap_dir_reg;
    logic [TIME_W-1:0]  cap_time_reg;

    logic [DIVISOR_W-1:0]  prod_reg, prod_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    rem_shift;
    logic                  quo_bit;
    logic [HP_W-1:0]       hp_new;

    logic [NUM_MOTORS-1:0] run_reg, run_next;
    logic [NUM_MOTORS-1:0] step_reg, step_next;
    logic [NUM_MOTORS-1:0] dir_reg, dir_next;
    logic [HP_W-1:0]       hp_reg [NUM_MOTORS];
    logic [TIME_W-1:0]     last_reg [NUM_MOTORS];

    logic [NUM_MOTORS-1:0] own_sel;
    logic [NUM_MOTORS-1:0] other_sel;
    logic [NUM_MOTORS-1:0] halt_req;
    logic [NUM_MOTORS-1:0] halt_eff;
    logic [NUM_MOTORS-1:0] set_hp;
    logic [NUM_MOTORS-1:0] toggle;
    logic [TIME_W-1:0]     elapsed [NUM_MOTORS];
    logic                  motor_ok;
    logic                  conflict;

    logic [NUM_MOTORS-1:0] step_out_reg, dir_out_reg, run_out_reg;
    logic                  conflict_out_reg;

    assign motor_ok = (cap_motor_reg != '0) &&
                      (ID_W'(cap_motor_reg) <= ID_W'(NUM_MOTORS));
    assign status.needs_div = (cap_cmd_reg == CMD_SET_SPEED) && motor_ok &&
                              (cap_rpm_reg != '0);

    // Restoring division of the microseconds per minute by the step rate.
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign quo_bit   = (rem_shift >= {1'b0, prod_reg});
    assign hp_new    = (|quo_reg[DIVIDEND_W-1:HP_W]) ? '1 : quo_reg[HP_W-1:0];

    always_comb
    begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (ctrl.mul)
        begin
            prod_next = ((cap_motor_reg == SPECIAL_MOTOR) ?
                         DIVISOR_W'(spr_special_reg) : DIVISOR_W'(spr_default_reg)) *
                        DIVISOR_W'(cap_rpm_reg);
            rem_next  = '0;
            quo_next  = US_PER_MINUTE;
        end
        else if (ctrl.div_step)
        begin
            rem_next = quo_bit ? DIVISOR_W'(rem_shift - {1'b0, prod_reg})
                               : DIVISOR_W'(rem_shift);
            quo_next = {quo_reg[DIVIDEND_W-2:0], quo_bit};
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            own_sel[i] = motor_ok && (cap_motor_reg == MOTOR_W'(i + 1));
            other_sel[i] = 1'b0;
            elapsed[i] = cap_time_reg - last_reg[i];
        end
        other_sel[0] = (cap_motor_reg == PAIR_MOTOR_B);
        other_sel[1] = (cap_motor_reg == PAIR_MOTOR_A);
        halt_req = '0;
        set_hp   = '0;
        toggle   = '0;
        conflict = 1'b0;
        dir_next = dir_reg;
        case (cap_cmd_reg)
            CMD_SET_SPEED:
            begin
                if (motor_ok)
                begin
                    dir_next = (dir_reg & ~own_sel) | (cap_dir_reg ? own_sel : '0);
                    conflict = |(other_sel & run_reg & (dir_reg ^ {NUM_MOTORS{cap_dir_reg}}));
                    if (conflict)
                    begin
                        halt_req = other_sel;
                    end
                    if (cap_rpm_reg != '0)
                    begin
                        set_hp = own_sel;
                    end
                    else
                    begin
                        halt_req = halt_req | own_sel;
                    end
                end
            end
            CMD_STOP:
            begin
                halt_req = own_sel;
            end
            CMD_STOP_ALL:
            begin
                halt_req = '1;
            end
            CMD_TICK:
            begin
                for (int i = 0; i < NUM_MOTORS; i++)
                begin
                    toggle[i] = run_reg[i] && (hp_reg[i] != '0) &&
                                (elapsed[i] >= TIME_W'(hp_reg[i]));
                end
            end
            default:
            begin
                halt_req = '0;
            end
        endcase
        halt_eff  = halt_req & run_reg;
        run_next  = (run_reg & ~halt_eff) | set_hp;
        step_next = (step_reg & ~halt_eff) ^ toggle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_special_reg <= SPR_SPECIAL_RST;
            spr_default_reg <= SPR_DEFAULT_RST;
            invert_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SPR_SPECIAL: spr_special_reg <= cfg_data;
                REG_SPR_DEFAULT: spr_default_reg <= cfg_data;
                REG_INVERT:      invert_reg      <= cfg_data[NUM_MOTORS-1:0];
                default:         invert_reg      <= invert_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cap_cmd_reg   <= command;
            cap_motor_reg <= motor_id;
            cap_rpm_reg   <= rpm;
            cap_dir_reg   <= direction;
            cap_time_reg  <= time_us;
        end
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        if (ctrl.commit)
        begin
            step_out_reg     <= step_next;
            dir_out_reg      <= dir_next ^ invert_reg;
            run_out_reg      <= run_next;
            conflict_out_reg <= conflict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= '0;
            step_reg <= '0;
            dir_reg  <= '1;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                hp_reg[i]   <= '0;
                last_reg[i] <= '0;
            end
        end
        else if (ctrl.commit)
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
            dir_reg  <= dir_next;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                if (set_hp[i])
                begin
                    hp_reg[i] <= hp_new;
                end
                else if (halt_eff[i])
                begin
                    hp_reg[i] <= '0;
                end
                if (toggle[i])
                begin
                    last_reg[i] <= cap_time_reg;
                end
            end
        end
    end

    assign step_levels   = step_out_reg;
    assign dir_levels    = dir_out_reg;
    assign running_mask  = run_out_reg;
    assign conflict_stop = conflict_out_reg;

endmodule

/* sv/multi_channel_step_pulse_generator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-channel step pulse generator
// Takes set speed, stop, stop all and tick commands and returns one beat
// with the step, direction and running levels of every motor.
// ----------------------------------------------------------------------------
// One command is in flight at a time. Stop, stop all, tick and any set speed
// that needs no division go from the multiply state straight to commit; a
// set speed with a valid motor and a nonzero rpm passes through the restoring
// divider between multiply and commit, which produces one of 26 quotient bits
// per cycle. The input is ready again in the cycle after the result is
// loaded, and a result waiting on the output does not hold up the next
// command until that command is ready to commit. Configuration writes are
// always taken and must only be issued while the block is idle.
module multi_channel_step_pulse_generator_top #(
    parameter int NUM_MOTORS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    spg_cmd_if.sink     cmd,
    spg_res_if.source   res,
    spg_cfg_if.sink     cfg
);
    import spg_pkg::*;

    spg_ctrl_t   ctrl;
    spg_status_t status;

    assign cfg.ready = 1'b1;

    spg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    spg_datapath #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .status        (status),
        .command       (cmd.command),
        .motor_id      (cmd.motor_id),
        .rpm           (cmd.rpm),
        .direction     (cmd.direction),
        .time_us       (cmd.time_us),
        .cfg_write     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .step_levels   (res.step_levels),
        .dir_levels    (res.dir_levels),
        .running_mask  (res.running_mask),
        .conflict_stop (res.conflict_stop)
    );

endmodule

/* sv/spg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse generator checker
// Port-level checks on the command and result channels.
// ----------------------------------------------------------------------------
module spg_checker #(
    parameter int NUM_MOTORS = 5
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [NUM_MOTORS-1:0] step_levels,
    input logic [NUM_MOTORS-1:0] running_mask,
    input logic                  conflict_stop
);

    // A stopped motor always has its step pin low.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((step_levels & ~running_mask) == '0))
        else $error("step level high on a stopped motor");

    // After a conflict stop the two paired motors cannot both run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && conflict_stop) |-> !(running_mask[0] && running_mask[1]))
        else $error("paired motors both running after conflict stop");

    // Only one command is in flight, so an accepted beat drops ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready stayed high after an accepted beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(step_levels) &&
                                       $stable(running_mask) && $stable(conflict_stop)))
        else $error("stalled result beat changed");

endmodule

bind multi_channel_step_pulse_generator_top spg_checker #(
    .NUM_MOTORS (NUM_MOTORS)
) u_spg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (cmd.valid),
    .in_ready      (cmd.ready),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .step_levels   (res.step_levels),
    .running_mask  (res.running_mask),
    .conflict_stop (res.conflict_stop)
);

/* bench/tb_multi_channel_step_pulse_generator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multi-channel step pulse generator
// Drives set speed, stop, stop all and tick commands under several register
// settings, with random idling on both sides and periods of back-pressure.
// A cycle-free model of the motor channels predicts every status beat, and
// each beat that comes back is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_multi_channel_step_pulse_generator_top;
    import spg_pkg::*;

    localparam int NM             = 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [MOTOR_W-1:0] motor_id;
        logic [RPM_W-1:0]   rpm;
        logic               direction;
        logic [TIME_W-1:0]  time_us;
    } motor_cmd_t;

    typedef struct packed {
        logic [NM-1:0] step_levels;
        logic [NM-1:0] dir_levels;
        logic [NM-1:0] running_mask;
        logic          conflict_stop;
    } motor_status_t;

    logic clk;
    logic rst_n;

    spg_cmd_if                     cmd_if ();
    spg_res_if #(.NUM_MOTORS(NM))  res_if ();
    spg_cfg_if                     cfg_if ();

    multi_channel_step_pulse_generator_top #(
        .NUM_MOTORS(NM)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    logic [NM-1:0]     motor_running;
    logic [NM-1:0]     motor_level;
    logic [NM-1:0]     motor_dir;
    logic [HP_W-1:0]   half_us [NM];
    logic [TIME_W-1:0] last_toggle_us [NM];
    logic [SPR_W-1:0]  spr_special;
    logic [SPR_W-1:0]  spr_default;
    logic [NM-1:0]     dir_invert;

    motor_status_t     pending_status [$];
    motor_status_t     want;
    logic [TIME_W-1:0] now_us;

    int  fail_count;
    int  n_cmd;
    int  n_set;
    int  n_tick;
    int  n_toggle;
    int  n_conflict;
    int  n_cfg;
    int  n_settings;
    int  idle_cycles;
    int  hold_request;
    bit  src_gaps;
    bit  snk_gaps;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [HP_W-1:0] half_period_us(input logic [MOTOR_W-1:0] motor,
                                                       input logic [RPM_W-1:0] rpm);
        logic [31:0] dividend;
        logic [31:0] divisor;
        logic [31:0] quotient;
        dividend = 32'(US_PER_MINUTE);
        divisor  = 32'((motor == SPECIAL_MOTOR) ? spr_special : spr_default) * 32'(rpm);
        if (divisor == 0)
        begin
            return '1;
        end
        quotient = dividend / divisor;
        return (quotient > 32'hFFFF) ? '1 : quotient[HP_W-1:0];
    endfunction

    function automatic void halt_motor(input int idx);
        if (motor_running[idx])
        begin
            motor_running[idx] = 1'b0;
            motor_level[idx]   = 1'b0;
            half_us[idx]       = '0;
        end
    endfunction

    function automatic motor_status_t advance_motors(input motor_cmd_t c);
        motor_status_t s;
        int            idx;
        int            other;
        logic          known;
        s.conflict_stop = 1'b0;
        known = (c.motor_id >= 1) && (c.motor_id <= NM);
        idx   = int'(c.motor_id) - 1;
        case (c.command)
            CMD_SET_SPEED:
            begin
                if (known)
                begin
                    motor_dir[idx] = c.direction;
                    if (c.motor_id == PAIR_MOTOR_A || c.motor_id == PAIR_MOTOR_B)
                    begin
                        other = (c.motor_id == PAIR_MOTOR_A) ? 1 : 0;
                        if (motor_running[other] && motor_dir[other] != c.direction)
                        begin
                            halt_motor(other);
                            s.conflict_stop = 1'b1;
                        end
                    end
                    if (c.rpm != 0)
                    begin
                        half_us[idx]       = half_period_us(c.motor_id, c.rpm);
                        motor_running[idx] = 1'b1;
                    end
                    else
                    begin
                        halt_motor(idx);
                    end
                end
            end
            CMD_STOP:
            begin
                if (known)
                begin
                    halt_motor(idx);
                end
            end
            CMD_STOP_ALL:
            begin
                for (int i = 0; i < NM; i++)
                begin
                    halt_motor(i);
                end
            end
            default:
            begin
                for (int i = 0; i < NM; i++)
                begin
                    if (motor_running[i] && half_us[i] != 0 &&
                        (c.time_us - last_toggle_us[i]) >= TIME_W'(half_us[i]))
                    begin
                        motor_level[i]    = ~motor_level[i];
                        last_toggle_us[i] = c.time_us;
                        n_toggle++;
                    end
                end
            end
        endcase
        s.step_levels  = motor_level;
        s.dir_levels   = motor_dir ^ dir_invert;
        s.running_mask = motor_running;
        return s;
    endfunction

    function automatic motor_cmd_t make_cmd(input logic [CMD_W-1:0] command,
                                            input logic [MOTOR_W-1:0] motor,
                                            input logic [RPM_W-1:0] rpm,
                                            input logic direction,
                                            input logic [TIME_W-1:0] t);
        motor_cmd_t c;
        c.command   = command;
        c.motor_id  = motor;
        c.rpm       = rpm;
        c.direction = direction;
        c.time_us   = t;
        return c;
    endfunction

    function automatic motor_cmd_t random_cmd();
        motor_cmd_t c;
        int         pick;
        pick        = $urandom_range(0, 99);
        c.motor_id  = MOTOR_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                           : $urandom_range(1, NM));
        c.rpm       = RPM_W'(($urandom_range(0, 9) == 0) ? 0 :
                             (($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 255)));
        c.direction = 1'($urandom_range(0, 1));
        c.time_us   = $urandom;
        if (pick < 55)
        begin
            c.command = CMD_TICK;
            if ($urandom_range(0, 49) == 0)
            begin
                now_us = $urandom;
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                now_us = now_us + $urandom_range(0, 70000);
            end
            else
            begin
                now_us = now_us + $urandom_range(0, 400);
            end
            c.time_us = now_us;
        end
        else if (pick < 80)
        begin
            c.command = CMD_SET_SPEED;
        end
        else if (pick < 93)
        begin
            c.command = CMD_STOP;
        end
        else
        begin
            c.command = CMD_STOP_ALL;
        end
        return c;
    endfunction

    task automatic reset_model();
        motor_running = '0;
        motor_level   = '0;
        motor_dir     = '1;
        spr_special   = SPR_SPECIAL_RST;
        spr_default   = SPR_DEFAULT_RST;
        dir_invert    = '0;
        now_us        = '0;
        for (int i = 0; i < NM; i++)
        begin
            half_us[i]        = '0;
            last_toggle_us[i] = '0;
        end
    endtask

    task automatic send_cmd(input motor_cmd_t c);
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.command   <= c.command;
        cmd_if.motor_id  <= c.motor_id;
        cmd_if.rpm       <= c.rpm;
        cmd_if.direction <= c.direction;
        cmd_if.time_us   <= c.time_us;
        do @(posedge clk); while (!cmd_if.ready);
        pending_status.push_back(advance_motors(c));
        n_cmd++;
        if (c.command == CMD_SET_SPEED)
        begin
            n_set++;
        end
        if (c.command == CMD_TICK)
        begin
            n_tick++;
        end
        if (pending_status[$].conflict_stop)
        begin
            n_conflict++;
        end
    endtask

    task automatic drain_status();
        cmd_if.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            REG_SPR_SPECIAL: spr_special = data;
            REG_SPR_DEFAULT: spr_default = data;
            REG_INVERT:      dir_invert  = data[NM-1:0];
            default:         ;
        endcase
        n_cfg++;
    endtask

    task automatic apply_config(input logic [SPR_W-1:0] special, input logic [SPR_W-1:0] other,
                                input logic [NM-1:0] mask, input bit poke_unused);
        logic [CFG_DATA_W-1:0] word;
        drain_status();
        word = CFG_DATA_W'($urandom);
        word[NM-1:0] = mask;
        write_reg(REG_SPR_SPECIAL, special);
        write_reg(REG_SPR_DEFAULT, other);
        write_reg(REG_INVERT, word);
        if (poke_unused)
        begin
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        end
        cfg_if.valid <= 1'b0;
        n_settings++;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_cmd(random_cmd());
    endtask

    task automatic test_directed();
        src_gaps = 1'b1;
        snk_gaps = 1'b1;
        send_cmd(make_cmd(CMD_TICK,      3'd0, 8'd0,   1'b0, 32'h0000_0000));
        send_cmd(make_cmd(CMD_SET_SPEED, 3'd1, 8'd255, 1'b1, 32'hFFFF_FFFF));
        send_cmd(make_cmd(CMD_SET_SPEED, 3'd2, 8'd255, 1'b0, 32'h0));
        send_cmd(make_cmd(CMD_SET_SPEED, 3'd1, 8'd1,   1'b1, 32'h0));
        send_cmd(make_cmd(CMD_SET_SPEED, 3'd3, 8'd255, 1'b0, 32'h0));
        send_cmd(make_cmd(CMD_SET_SPEED, 3'd4, 8'd128, 1'b1, 32'h0));
        send_cmd(make_cmd(CMD_SET_SPEED, 3'd5, 8'd1,   1'b0, 32'h0));
        send_cmd(make_cmd(CMD_SET_SPEED, 3'd0, 8'd10,  1'b0, 32'h0));
        send_cmd(make_cmd(CMD_SET_SPEED, 3'd6, 8'd10,  1'b0, 32'h0));
        send_cmd(make_cmd(CMD_STOP,      3'd7, 8'd0,   1'b1, 32'h0));
        send_cmd(make_cmd(CMD_TICK,      3'd7, 8'd255, 1'b1, 32'hFFFF_FFFF));
        send_cmd(make_cmd(CMD_TICK,      3'd0, 8'd0,   1'b0, 32'h0000_0010));
        send_cmd(make_cmd(CMD_TICK,      3'd0, 8'd0,   1'b0, 32'h0001_0000));
        send_cmd(make_cmd(CMD_STOP,      3'd4, 8'd0,   1'b0, 32'h0));
        send_cmd(make_cmd(CMD_STOP,      3'd4, 8'd0,   1'b0, 32'h0));
        send_cmd(make_cmd(CMD_SET_SPEED, 3'd2, 8'd0,   1'b1, 32'h0));
        send_cmd(make_cmd(CMD_SET_SPEED, 3'd5, 8'd0,   1'b1, 32'h0));
        send_cmd(make_cmd(CMD_TICK,      3'd0, 8'd0,   1'b0, 32'h8000_0000));
        send_cmd(make_cmd(CMD_STOP_ALL,  3'd0, 8'd0,   1'b0, 32'h0));
        send_cmd(make_cmd(CMD_STOP_ALL,  3'd5, 8'd0,   1'b0, 32'h0));
        send_cmd(make_cmd(CMD_TICK,      3'd0, 8'd0,   1'b0, 32'hFFFF_FFFF));
        send_cmd(make_cmd(CMD_SET_SPEED, 3'd2, 8'd200, 1'b1, 32'h0));
        send_cmd(make_cmd(CMD_SET_SPEED, 3'd1, 8'd50,  1'b1, 32'h0));
        send_cmd(make_cmd(CMD_TICK,      3'd0, 8'd0,   1'b0, 32'h7FFF_FFFF));
        send_cmd(make_cmd(CMD_STOP_ALL,  3'd0, 8'd0,   1'b0, 32'h0));
        drain_status();
    endtask

    task automatic test_register_settings();
        apply_config(16'd200, 16'd200, 5'b00000, 1'b1);
        run_random(70);
        apply_config(16'd65535, 16'd65535, 5'b11111, 1'b0);
        run_random(70);
        apply_config(16'd0, 16'd0, 5'b10101, 1'b0);
        run_random(70);
        apply_config(SPR_SPECIAL_RST, SPR_DEFAULT_RST, 5'b01010, 1'b0);
        run_random(70);
        apply_config(SPR_W'($urandom_range(200, 65535)), SPR_W'($urandom_range(200, 65535)),
                     NM'($urandom), 1'b1);
        run_random(70);
        apply_config(SPR_W'($urandom_range(200, 3200)), SPR_W'($urandom_range(200, 3200)),
                     NM'($urandom), 1'b0);
        run_random(70);
        drain_status();
    endtask

    task automatic test_output_backpressure();
        src_gaps     = 1'b0;
        hold_request = LONG_HOLD;
        run_random(40);
        drain_status();
        src_gaps = 1'b1;
    endtask

    task automatic test_sender_pause();
        run_random(20);
        drain_status();
        run_random(20);
        drain_status();
    endtask

    task automatic test_random_mix();
        for (int blk = 0; blk < 8; blk++)
        begin
            src_gaps = $urandom_range(0, 1);
            snk_gaps = $urandom_range(0, 1);
            run_random(60);
        end
        drain_status();
    endtask

    task automatic test_full_rate();
        apply_config(SPR_W'($urandom_range(200, 65535)), SPR_W'($urandom_range(200, 65535)),
                     NM'($urandom), 1'b0);
        src_gaps = 1'b0;
        snk_gaps = 1'b0;
        run_random(100);
        drain_status();
    endtask

    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                res_if.ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                res_if.ready <= 1'b1;
            end
            else if (snk_gaps && $urandom_range(0, 7) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                res_if.ready <= 1'b1;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_status.size() == 0)
            begin
                $error("status beat arrived with no command outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                if (res_if.step_levels !== want.step_levels)
                begin
                    $error("step_levels: expected %b, got %b", want.step_levels,
                           res_if.step_levels);
                    fail_count++;
                end
                if (res_if.dir_levels !== want.dir_levels)
                begin
                    $error("dir_levels: expected %b, got %b", want.dir_levels,
                           res_if.dir_levels);
                    fail_count++;
                end
                if (res_if.running_mask !== want.running_mask)
                begin
                    $error("running_mask: expected %b, got %b", want.running_mask,
                           res_if.running_mask);
                    fail_count++;
                end
                if (res_if.conflict_stop !== want.conflict_stop)
                begin
                    $error("conflict_stop: expected %b, got %b", want.conflict_stop,
                           res_if.conflict_stop);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no beat moved for %0d cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        cmd_if.valid     <= 1'b0;
        cmd_if.command   <= CMD_TICK;
        cmd_if.motor_id  <= '0;
        cmd_if.rpm       <= '0;
        cmd_if.direction <= 1'b0;
        cmd_if.time_us   <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= REG_SPR_SPECIAL;
        cfg_if.data      <= '0;
        rst_n            <= 1'b0;
        fail_count   = 0;
        n_cmd        = 0;
        n_set        = 0;
        n_tick       = 0;
        n_toggle     = 0;
        n_conflict   = 0;
        n_cfg        = 0;
        n_settings   = 0;
        hold_request = 0;
        src_gaps     = 1'b0;
        snk_gaps     = 1'b0;
        reset_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_settings();
        test_output_backpressure();
        test_sender_pause();
        test_random_mix();
        test_full_rate();

        drain_status();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_status.size() != 0)
        begin
            $error("%0d status beats never arrived", pending_status.size());
            fail_count++;
        end
        $display("Ran %0d commands: %0d speed sets, %0d ticks, %0d step toggles, %0d pair stops.",
                 n_cmd, n_set, n_tick, n_toggle, n_conflict);
        $display("Wrote %0d registers across %0d settings, with stalls and long back-pressure.",
                 n_cfg, n_settings);
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/spg_pkg.sv
sv/spg_if.sv
sv/spg_ctrl.sv
sv/spg_datapath.sv
sv/multi_channel_step_pulse_generator_top.sv
sv/spg_checker.sv
bench/tb_multi_channel_step_pulse_generator_top.sv
